// ===== rtl/core/mmh_pkg.sv =====
// Package for the min-max heap priority queue.
// Holds sizes, request and status codes, entry and sequencer control types.
// No dependencies.
package mmh_pkg;
	localparam int Capacity = 1024;
	localparam int AddrW    = $clog2(Capacity + 1);
	localparam int CountW   = $clog2(Capacity + 1);

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_MAX    = 2'd1;
	localparam logic [1:0] REQ_MIN    = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_LARGEST  = 3'd1;
	localparam logic [2:0] ST_SMALLEST = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [31:0]        ident;
		logic signed [31:0] prio;
	} entry_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [31:0]        job_ident;
		logic signed [31:0] job_priority;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [31:0]        out_ident;
		logic signed [31:0] out_priority;
		logic [10:0]        waiting_count;
	} rsp_t;

	// Memory port request from the sequencer.
	typedef struct packed {
		logic             rd_en;
		logic [AddrW-1:0] rd_addr;
		logic             wr_en;
		logic [AddrW-1:0] wr_addr;
		entry_t           wr_data;
	} mem_ctl_t;

	// True when slot x sits on a min level (even depth).
	function automatic logic on_min_level(input logic [AddrW-1:0] x);
		logic [$clog2(AddrW)-1:0] msb;
		msb = '0;
		for (int i = 0; i < AddrW; i++) begin
			if (x[i]) msb = ($clog2(AddrW))'(i);
		end
		return ~msb[0];
	endfunction
endpackage

// ===== rtl/core/mmh_stream_if.sv =====
// Valid/ready stream interface carrying one payload type.
// Depends on mmh_pkg only through the payload types chosen by users.
interface mmh_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mmh_store.sv =====
// Entry store of the heap: one write port and one registered read port.
// Depends on mmh_pkg. Contents are undefined until written.
module mmh_store (
	input  logic             clk,
	input  mmh_pkg::mem_ctl_t ctl,
	output mmh_pkg::entry_t   rd_data
);
	import mmh_pkg::*;
	entry_t mem [Capacity + 1];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) mem[ctl.wr_addr] <= ctl.wr_data;
		if (ctl.rd_en) rd_data <= mem[ctl.rd_addr];
	end
endmodule

// ===== rtl/core/mmh_seq.sv =====
// Sequencer for the heap: walks insert bubble-up and removal sink-down
// one memory access per cycle with a single shared priority comparator.
// Depends on mmh_pkg and mmh_store (through its ports).
module mmh_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mmh_pkg::req_t     req,
	output logic              busy,
	output logic              done,
	output mmh_pkg::rsp_t     rsp,
	output mmh_pkg::mem_ctl_t mem,
	input  mmh_pkg::entry_t   rd_data
);
	import mmh_pkg::*;

	localparam int CandW = AddrW + 2;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_INS_RD   = 5'd1;  // read parent of the new slot
	localparam logic [4:0] S_INS_CMP  = 5'd2;
	localparam logic [4:0] S_RISE_RD  = 5'd3;  // read grandparent
	localparam logic [4:0] S_RISE_CMP = 5'd4;
	localparam logic [4:0] S_TOP_RD2  = 5'd5;
	localparam logic [4:0] S_TOP_RD3  = 5'd6;
	localparam logic [4:0] S_TOP_SEL  = 5'd7;
	localparam logic [4:0] S_OUT_RD   = 5'd8;  // read the removed slot
	localparam logic [4:0] S_OUT_GET  = 5'd9;
	localparam logic [4:0] S_LAST_RD  = 5'd10; // read last slot
	localparam logic [4:0] S_LAST_GET = 5'd11;
	localparam logic [4:0] S_SINK     = 5'd12; // start a sink level
	localparam logic [4:0] S_CAND_RD  = 5'd13; // issue candidate reads
	localparam logic [4:0] S_CAND_CMP = 5'd14;
	localparam logic [4:0] S_SWAP     = 5'd15;
	localparam logic [4:0] S_PAR_RD   = 5'd16; // read parent of best
	localparam logic [4:0] S_PAR_CMP  = 5'd17;
	localparam logic [4:0] S_WR_CUR   = 5'd18;
	localparam logic [4:0] S_DONE     = 5'd19;

	logic [4:0]        state_q;
	logic [CountW-1:0] count_q;
	logic [AddrW-1:0]  pos_q, best_q, cand_q;
	logic [2:0]        ci_q;
	entry_t            cur_q, best_e_q, top_e_q, out_q;
	logic              want_max_q;
	logic [2:0]        status_q;

	logic signed [31:0] cmp_a, cmp_b;
	logic               beats;
	logic [CandW-1:0]   cand_w;
	logic               cand_ok;
	logic [AddrW-1:0]   next_slot;
	logic               child_best;

	// Shared comparator: does a beat b in the current direction?
	assign beats = want_max_q ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

	assign next_slot  = AddrW'(count_q + 1'b1);
	assign child_best = {2'b00, best_q} < {pos_q, 2'b00};

	// Candidates in order: two children, then four grandchildren.
	always_comb begin
		cand_w = (ci_q < 3'd2) ? ({1'b0, pos_q, 1'b0} + CandW'(ci_q))
		                       : ({pos_q, 2'b00} + CandW'(ci_q - 3'd2));
		cand_ok = (ci_q < 3'd6) && (cand_w <= CandW'(count_q));
	end

	always_comb begin
		cmp_a = rd_data.prio;
		cmp_b = cur_q.prio;
		unique case (state_q) inside
			S_INS_CMP, S_RISE_CMP: begin cmp_a = cur_q.prio; cmp_b = rd_data.prio; end
			S_TOP_SEL:             begin cmp_a = top_e_q.prio; cmp_b = rd_data.prio; end
			S_CAND_CMP:            begin cmp_a = rd_data.prio; cmp_b = best_e_q.prio; end
			default: ;
		endcase
	end

	// cur_q holds the moving entry; pos_q is the hole where it logically
	// sits. Steps write displaced entries to the hole, or cur_q into place.
	always_comb begin
		mem = '0;
		unique case (state_q) inside
			S_INS_RD:  begin mem.rd_en = 1'b1; mem.rd_addr = pos_q >> 1; end
			S_INS_CMP, S_RISE_CMP: begin
				if (beats) begin
					mem.wr_en = 1'b1; mem.wr_addr = pos_q; mem.wr_data = rd_data;
				end
			end
			S_RISE_RD: begin
				if (pos_q > AddrW'(3)) begin mem.rd_en = 1'b1; mem.rd_addr = pos_q >> 2; end
			end
			S_TOP_RD2: begin mem.rd_en = 1'b1; mem.rd_addr = AddrW'(2); end
			S_TOP_RD3: begin mem.rd_en = 1'b1; mem.rd_addr = AddrW'(3); end
			S_OUT_RD:  begin mem.rd_en = 1'b1; mem.rd_addr = pos_q; end
			S_LAST_RD: begin mem.rd_en = 1'b1; mem.rd_addr = AddrW'(count_q); end
			S_CAND_RD: begin
				if (cand_ok) begin mem.rd_en = 1'b1; mem.rd_addr = AddrW'(cand_w); end
			end
			S_SWAP: begin
				if (best_q != pos_q) begin
					mem.wr_en = 1'b1; mem.wr_addr = pos_q; mem.wr_data = best_e_q;
				end
			end
			S_PAR_RD:  begin mem.rd_en = 1'b1; mem.rd_addr = pos_q >> 1; end
			S_PAR_CMP: begin
				if (beats) begin
					mem.wr_en = 1'b1; mem.wr_addr = pos_q >> 1; mem.wr_data = cur_q;
				end
			end
			S_WR_CUR:  begin mem.wr_en = 1'b1; mem.wr_addr = pos_q; mem.wr_data = cur_q; end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign rsp  = '{status_q, out_q.ident, out_q.prio, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			pos_q      <= '0;
			best_q     <= '0;
			cand_q     <= '0;
			ci_q       <= '0;
			cur_q      <= '0;
			best_e_q   <= '0;
			top_e_q    <= '0;
			out_q      <= '0;
			want_max_q <= 1'b0;
			status_q   <= ST_EMPTY;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					out_q <= '0;
					unique case (req.req_type)
						REQ_INSERT: begin
							if (count_q < CountW'(Capacity)) begin
								status_q   <= ST_INSERTED;
								count_q    <= count_q + 1'b1;
								pos_q      <= next_slot;
								cur_q      <= '{req.job_ident, req.job_priority};
								want_max_q <= on_min_level(next_slot);
								state_q    <= (count_q == '0) ? S_WR_CUR : S_INS_RD;
							end else begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end
						end
						REQ_MAX: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else if (count_q < CountW'(3)) begin
								status_q   <= ST_LARGEST;
								want_max_q <= 1'b1;
								pos_q      <= AddrW'(count_q);
								state_q    <= S_OUT_RD;
							end else begin
								status_q   <= ST_LARGEST;
								want_max_q <= 1'b1;
								state_q    <= S_TOP_RD2;
							end
						end
						REQ_MIN: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								status_q   <= ST_SMALLEST;
								want_max_q <= 1'b0;
								pos_q      <= AddrW'(1);
								state_q    <= S_OUT_RD;
							end
						end
						default: begin
							status_q <= ST_EMPTY;
							state_q  <= S_DONE;
						end
					endcase
				end
				S_INS_RD: state_q <= S_INS_CMP;
				S_INS_CMP: begin
					// Direction was set from the level of the new slot.
					if (beats) pos_q <= pos_q >> 1;
					else want_max_q <= ~want_max_q;
					state_q <= S_RISE_RD;
				end
				S_RISE_RD: state_q <= (pos_q > AddrW'(3)) ? S_RISE_CMP : S_WR_CUR;
				S_RISE_CMP: begin
					if (beats) begin
						pos_q   <= pos_q >> 2;
						state_q <= S_RISE_RD;
					end else state_q <= S_WR_CUR;
				end
				S_TOP_RD2: state_q <= S_TOP_RD3;
				S_TOP_RD3: begin
					top_e_q <= rd_data; // slot 2
					state_q <= S_TOP_SEL;
				end
				S_TOP_SEL: begin
					// Slot 3 wins a tie with slot 2.
					if (beats) begin
						pos_q <= AddrW'(2); out_q <= top_e_q;
					end else begin
						pos_q <= AddrW'(3); out_q <= rd_data;
					end
					state_q <= S_LAST_RD;
				end
				S_OUT_RD: state_q <= S_OUT_GET;
				S_OUT_GET: begin
					out_q   <= rd_data;
					state_q <= S_LAST_RD;
				end
				S_LAST_RD: state_q <= S_LAST_GET;
				S_LAST_GET: begin
					cur_q   <= rd_data;
					count_q <= count_q - 1'b1;
					state_q <= S_SINK;
				end
				S_SINK: begin
					if (pos_q > AddrW'(count_q)) state_q <= S_DONE;
					else if ({1'b0, pos_q, 1'b0} > CandW'(count_q)) state_q <= S_WR_CUR;
					else begin
						best_q   <= pos_q;
						best_e_q <= cur_q;
						ci_q     <= 3'd0;
						state_q  <= S_CAND_RD;
					end
				end
				S_CAND_RD: begin
					cand_q  <= AddrW'(cand_w);
					state_q <= cand_ok ? S_CAND_CMP : S_SWAP;
				end
				S_CAND_CMP: begin
					if (beats) begin best_q <= cand_q; best_e_q <= rd_data; end
					ci_q    <= ci_q + 3'd1;
					state_q <= S_CAND_RD;
				end
				S_SWAP: begin
					if (best_q == pos_q) state_q <= S_WR_CUR;
					else begin
						pos_q   <= best_q;
						state_q <= child_best ? S_WR_CUR : S_PAR_RD;
					end
				end
				S_PAR_RD: state_q <= S_PAR_CMP;
				S_PAR_CMP: begin
					// Parent beats the moving entry: they trade places.
					if (beats) cur_q <= rd_data;
					state_q <= S_SINK;
				end
				S_WR_CUR: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/min_max_heap_priority_queue_top.sv =====
// Top level of the min-max heap priority queue.
// Depends on mmh_pkg, mmh_stream_if, mmh_seq and mmh_store.
//
//  channel | dir | payload
//  req     | in  | req_type, job_ident, job_priority
//  rsp     | out | status, out_ident, out_priority, waiting_count
//
// The sequencer stays busy while an insert bubbles up by grandparent steps
// (an insert into an empty queue writes its slot directly) and while a
// removal sinks level by level. Empty, full and unknown requests go
// straight to done. Reset clears count and control state, not the store.
// A result waits in its output register; requests are refused meanwhile.
module min_max_heap_priority_queue_top (
	input logic clk,
	input logic arst_n,
	mmh_stream_if.sink   req,
	mmh_stream_if.source rsp
);
	import mmh_pkg::*;
	mmh_pkg::mem_ctl_t mem;
	entry_t rd_data;
	logic   busy, done, hold_q;
	rsp_t   rsp_d;

	assign req.ready = !busy && !hold_q;

	mmh_seq u_seq (
		.clk, .arst_n, .start(req.valid && req.ready), .req(req.data),
		.busy, .done, .rsp(rsp_d), .mem, .rd_data
	);
	mmh_store u_store (.clk, .ctl(mem), .rd_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_q <= 1'b0;
		else if (done) hold_q <= 1'b1;
		else if (rsp.ready) hold_q <= 1'b0;
	end
	always_ff @(posedge clk) if (done) rsp.data <= rsp_d;
	assign rsp.valid = hold_q;
endmodule

// ===== rtl/core/mmh_checker.sv =====
// Port checker for the heap queue, bound to the top level.
// No dependencies.
module mmh_checker (
	input logic clk, arst_n, in_v, in_r, out_v, out_r,
	input logic [2:0] st
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && !out_r |=> out_v) else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_v |-> !in_r) else $error("accept while result held");
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_v |-> st <= 3'd4) else $error("bad status");
endmodule
bind min_max_heap_priority_queue_top mmh_checker u_chk (
	.clk, .arst_n, .in_v(req.valid), .in_r(req.ready),
	.out_v(rsp.valid), .out_r(rsp.ready), .st(rsp.data.status));

// ===== tb/min_max_heap_priority_queue_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the min-max heap priority queue testbench.
// Holds a behavioral min-max heap and checks response beats; depends on mmh_pkg.
package min_max_heap_priority_queue_tb_pkg;
	import mmh_pkg::*;

	class heap_scoreboard;
		entry_t slots[Capacity + 1];
		int unsigned held;
		rsp_t pending[$];
		int unsigned errors;

		function new();
			held = 0;
			errors = 0;
		endfunction

		function bit on_min_tier(int unsigned x);
			int unsigned d;
			d = 0;
			while (x > 1) begin
				x = x >> 1;
				d++;
			end
			return (d % 2) == 0;
		endfunction

		function bit wins(logic signed [31:0] a, logic signed [31:0] b, bit want_max);
			return want_max ? (a > b) : (a < b);
		endfunction

		function void exchange(int unsigned a, int unsigned b);
			entry_t t;
			t = slots[a];
			slots[a] = slots[b];
			slots[b] = t;
		endfunction

		function void climb(int unsigned pos, bit want_max);
			while (pos > 3) begin
				if (!wins(slots[pos].prio, slots[pos >> 2].prio, want_max)) break;
				exchange(pos, pos >> 2);
				pos = pos >> 2;
			end
		endfunction

		function void settle(int unsigned pos, bit want_max);
			int unsigned best;
			int unsigned c;
			while ((pos << 1) <= held) begin
				best = pos;
				for (int i = 0; i < 6; i++) begin
					c = (i < 2) ? (pos << 1) + i : (pos << 2) + i - 2;
					if (c > held) break;
					if (wins(slots[c].prio, slots[best].prio, want_max)) best = c;
				end
				if (best == pos) return;
				exchange(pos, best);
				if (best < (pos << 2)) return;
				if (wins(slots[best >> 1].prio, slots[best].prio, want_max))
					exchange(best, best >> 1);
				pos = best;
			end
		endfunction

		// Updates the heap for one accepted request and queues its expected response.
		function void note_request(req_t r);
			rsp_t e;
			int unsigned top;
			int unsigned par;
			e = '0;
			e.status = ST_EMPTY;
			if (r.req_type == REQ_INSERT) begin
				if (held >= Capacity) begin
					e.status = ST_FULL;
				end else begin
					held++;
					slots[held].ident = r.job_ident;
					slots[held].prio = r.job_priority;
					if (held > 1) begin
						par = held >> 1;
						if (on_min_tier(held)) begin
							if (slots[held].prio > slots[par].prio) begin
								exchange(held, par);
								climb(par, 1);
							end else climb(held, 0);
						end else begin
							if (slots[held].prio < slots[par].prio) begin
								exchange(held, par);
								climb(par, 0);
							end else climb(held, 1);
						end
					end
					e.status = ST_INSERTED;
				end
			end else if (r.req_type == REQ_MAX && held > 0) begin
				if (held < 3) top = held;
				else top = (slots[2].prio > slots[3].prio) ? 2 : 3;
				e.out_ident = slots[top].ident;
				e.out_priority = slots[top].prio;
				exchange(top, held);
				held--;
				if (top <= held) settle(top, 1);
				e.status = ST_LARGEST;
			end else if (r.req_type == REQ_MIN && held > 0) begin
				e.out_ident = slots[1].ident;
				e.out_priority = slots[1].prio;
				exchange(1, held);
				held--;
				if (held > 0) settle(1, 0);
				e.status = ST_SMALLEST;
			end
			e.waiting_count = held[10:0];
			pending.push_back(e);
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("response beat with none expected: status %0d", a.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status expected %0d actual %0d", e.status, a.status);
				errors++;
			end
			if (a.out_ident !== e.out_ident) begin
				$error("out_ident expected %0h actual %0h", e.out_ident, a.out_ident);
				errors++;
			end
			if (a.out_priority !== e.out_priority) begin
				$error("out_priority expected %0d actual %0d", e.out_priority,
					a.out_priority);
				errors++;
			end
			if (a.waiting_count !== e.waiting_count) begin
				$error("waiting_count expected %0d actual %0d", e.waiting_count,
					a.waiting_count);
				errors++;
			end
		endfunction
	endclass
endpackage

// ===== tb/min_max_heap_priority_queue_top_tb.sv =====
`timescale 1ns / 100ps
// Top of the min-max heap priority queue testbench: clock, reset, request
// driver, response sink. Depends on mmh_pkg, mmh_stream_if and the tb package.
module min_max_heap_priority_queue_top_tb;
	import mmh_pkg::*;
	import min_max_heap_priority_queue_tb_pkg::*;

	logic clk;
	logic arst_n;
	int unsigned cycle_count;
	bit quiet_phase;
	bit hold_go;
	bit hold_done;
	int unsigned hold_off;

	mmh_stream_if #(.T(req_t)) req ();
	mmh_stream_if #(.T(rsp_t)) rsp ();

	heap_scoreboard board;

	min_max_heap_priority_queue_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 600000) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic bit idle_now();
		return !quiet_phase && ($urandom_range(99) < 13);
	endfunction

	// Offers one request beat, with random gaps, and waits for its acceptance.
	task automatic send_request(logic [1:0] kind, logic [31:0] id, logic [31:0] pr);
		while (idle_now()) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= '{req_type: kind, job_ident: id, job_priority: pr};
		do @(posedge clk); while (!req.ready);
		board.note_request(req.data);
	endtask

	task automatic random_request(int unsigned insert_pct);
		logic [1:0] kind;
		int unsigned r;
		r = $urandom_range(99);
		if (r < insert_pct) kind = REQ_INSERT;
		else if (r < insert_pct + (100 - insert_pct) / 2) kind = REQ_MAX;
		else kind = REQ_MIN;
		// Narrow priorities make ties common; wide ones cover every bit.
		send_request(kind, $urandom(),
			($urandom_range(1) == 0) ? $urandom_range(7) : $urandom());
	endtask

	// Response sink: random stalls plus one long hold-off while requests flow.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) board.check_response(rsp.data);
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				rsp.ready <= 1'b0;
			end else if (hold_go && !hold_done) begin
				hold_off <= 300;
				hold_done <= 1'b1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= !idle_now();
			end
		end
	end

	initial begin
		board = new();
		arst_n = 0;
		req.valid = 0;
		req.data = '0;
		quiet_phase = 0;
		hold_go = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty removals, extremes, ties, unknown type.
		send_request(REQ_MAX, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_request(REQ_MIN, 0, 0);
		send_request(2'd3, 32'hFFFF_FFFF, 32'h8000_0000);
		send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_request(REQ_INSERT, 0, 32'h8000_0000);
		send_request(REQ_INSERT, 32'h5555_5555, 0);
		send_request(REQ_INSERT, 32'hAAAA_AAAA, 0);
		send_request(REQ_INSERT, 1, 32'hFFFF_FFFF);
		send_request(REQ_INSERT, 2, 32'h7FFF_FFFF);
		send_request(REQ_INSERT, 3, 32'h8000_0000);
		send_request(2'd3, 0, 0);
		send_request(REQ_MAX, 0, 0);
		send_request(REQ_MAX, 0, 0);
		send_request(REQ_MIN, 0, 0);
		send_request(REQ_MIN, 0, 0);
		send_request(REQ_MAX, 0, 0);
		send_request(REQ_MIN, 0, 0);
		send_request(REQ_MIN, 0, 0);
		send_request(REQ_MIN, 0, 0);

		// Fill to capacity and past it, holding responses off for a while,
		// with a stretch with no idling in the middle.
		hold_go = 1;
		for (int i = 0; i < Capacity + 3; i++) begin
			quiet_phase = (i >= 300 && i < 500);
			send_request(REQ_INSERT, $urandom(),
				($urandom_range(3) == 0) ? $urandom_range(3) : $urandom());
		end
		quiet_phase = 0;
		// Removals from a full heap exercise the deepest sinks.
		for (int i = 0; i < 12; i++) random_request(0);
		req.valid <= 1'b0;
		while (board.pending.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/mmh_pkg.sv
rtl/core/mmh_stream_if.sv
rtl/core/mmh_store.sv
rtl/core/mmh_seq.sv
rtl/core/min_max_heap_priority_queue_top.sv
rtl/core/mmh_checker.sv
tb/min_max_heap_priority_queue_tb_pkg.sv
tb/min_max_heap_priority_queue_top_tb.sv
